FILE: design/token_escrow_table_macros.svh
// Assertion macros for the token escrow table checker.
// Included by the checker file; depends on nothing else.
`ifndef TOKEN_ESCROW_TABLE_MACROS_SVH
`define TOKEN_ESCROW_TABLE_MACROS_SVH
// Assert an implication that holds on every clock edge outside reset.
`define TET_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// Assert an implication whose consequent is checked in the cycle after the antecedent.
`define TET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

FILE: design/tet_pkg.sv
// Package for the token escrow table: status and request codes, slot record,
// CRC-16/CCITT-FALSE byte step. No dependencies.
package tet_pkg;
	localparam int NUM_SLOTS_DEF = 8;
	localparam int CRC_BYTES = 46;

	localparam logic [2:0] REQ_ADD = 3'd0;
	localparam logic [2:0] REQ_BUY = 3'd1;
	localparam logic [2:0] REQ_ERASE = 3'd2;
	localparam logic [2:0] REQ_LIST = 3'd3;
	localparam logic [2:0] REQ_RESET = 3'd4;

	localparam logic [3:0] ST_ADDED = 4'd0;
	localparam logic [3:0] ST_FULL = 4'd1;
	localparam logic [3:0] ST_RELEASED = 4'd2;
	localparam logic [3:0] ST_NOITEM = 4'd3;
	localparam logic [3:0] ST_CORRUPT = 4'd4;
	localparam logic [3:0] ST_MISMATCH = 4'd5;
	localparam logic [3:0] ST_ERASED = 4'd6;
	localparam logic [3:0] ST_NOTFOUND = 4'd7;
	localparam logic [3:0] ST_LISTENT = 4'd8;
	localparam logic [3:0] ST_LISTEND = 4'd9;
	localparam logic [3:0] ST_RESET = 4'd10;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Slot record held in the table memory: id, token, stored CRC.
	typedef struct packed {
		logic [31:0]  id_high;
		logic [63:0]  id_low;
		logic [255:0] token;
		logic [15:0]  crc;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	// Advance the CRC by one byte, most significant bit first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int j = 0; j < 8; j++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction
endpackage

FILE: design/tet_stream_if.sv
// Valid/ready channel interface carrying a parameterised payload.
// Standalone; no package dependency.
interface tet_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/tet_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module tet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                           clk,
	input  logic                                           we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
	input  logic [WIDTH-1:0]                               wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
	output logic [WIDTH-1:0]                               rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: design/tet_crc.sv
// Byte-serial CRC-16/CCITT-FALSE unit over one slot record (46 bytes).
// Depends on tet_pkg.
module tet_crc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tet_pkg::slot_rec_t  rec,
	output logic                done,
	output logic [15:0]         crc
);
	import tet_pkg::*;

	localparam int CW = $clog2(CRC_BYTES + 1);
	localparam int MW = 8 * CRC_BYTES;

	logic [MW-1:0] msg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [15:0]   crc_q;

	// Shift the message out a byte a cycle through the CRC step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(CRC_BYTES);
				crc_q  <= CRC_INIT;
				msg_q  <= {8'h01, rec.id_high, rec.id_low, 8'h00, rec.token};
			end else if (busy_q) begin
				crc_q <= crc_byte(crc_q, msg_q[MW-1 -: 8]);
				msg_q <= {msg_q[MW-9:0], 8'h00};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign crc = crc_q;
endmodule

FILE: design/token_escrow_table.sv
// Token escrow table top level: request sequencer over the slot memory.
// Depends on tet_pkg, tet_stream_if, tet_ram and tet_crc.
//
// A table of NUM_SLOTS escrow slots held in one synchronous RAM, with valid
// marks in flip-flops. Every request but reset scans the slots one per cycle
// through the RAM read port; then add (with a free or matching slot) and buy
// (with a matching entry) run the record through the byte-serial CRC unit;
// list emits one result per valid slot as the scan reaches it and holds the
// scan while the output register is full. One request is in work at a time;
// a new request is taken no earlier than the cycle in which the previous result leaves the output register.
module token_escrow_table #(
	parameter int NUM_SLOTS = tet_pkg::NUM_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tet_stream_if.sink   req,
	tet_stream_if.source res
);
	import tet_pkg::*;

	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_CRC, S_LIST, S_EMIT
	} state_t;

	state_t          state_q;
	logic [2:0]      type_q;
	logic [31:0]     idh_q;
	logic [63:0]     idl_q;
	logic [255:0]    tok_q;
	logic [NUM_SLOTS-1:0] valid_q;
	logic [AW:0]     scan_q;
	logic            rd_ok_s1;
	logic [AW-1:0]   rd_idx_s1;
	logic            hit_q, free_ok_q;
	logic [AW-1:0]   hit_q_idx, free_q;
	slot_rec_t       hit_rec_q;
	logic            out_v_q;
	logic [3:0]      out_st_q;
	logic [5:0]      out_slot_q;
	logic [31:0]     out_idh_q;
	logic [63:0]     out_idl_q;
	logic            out_rel_q, out_last_q;
	logic            crc_start;
	logic            crc_done;
	logic [15:0]     crc_val;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [AW-1:0]   ram_raddr;
	slot_rec_t       ram_wdata, ram_rdata;

	tet_ram #(.WIDTH(REC_W), .DEPTH(NUM_SLOTS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	tet_crc u_crc (
		.clk(clk), .arst_n(arst_n), .start(crc_start), .rec(crc_start ? ram_wdata : hit_rec_q),
		.done(crc_done), .crc(crc_val)
	);

	// Record to write or to check: new entry for add, stored one for buy
	always_comb begin
		ram_wdata.id_high = idh_q;
		ram_wdata.id_low  = idl_q;
		ram_wdata.token   = tok_q;
		ram_wdata.crc     = crc_val;
		if (type_q == REQ_BUY) begin
			ram_wdata = hit_rec_q;
		end
	end

	// Re-read the pending slot while a list stalls on a full output register
	assign ram_raddr = (state_q == S_LIST && out_v_q && !res.ready) ?
		rd_idx_s1 : scan_q[AW-1:0];

	assign ram_waddr = free_q;
	assign ram_we    = (state_q == S_CRC) && crc_done && (type_q == REQ_ADD);
	assign crc_start = (state_q == S_DECIDE) &&
		((type_q == REQ_ADD) ? (free_ok_q || hit_q) : ((type_q == REQ_BUY) && hit_q));

	assign req.ready = (state_q == S_IDLE) && !(out_v_q && !res.ready);
	assign res.valid = out_v_q;
	assign res.data.status      = out_st_q;
	assign res.data.slot_index  = out_slot_q;
	assign res.data.out_id_high = out_idh_q;
	assign res.data.out_id_low  = out_idl_q;
	assign res.data.release_res = out_rel_q;
	assign res.data.last        = out_last_q;

	// Sequencer: scan, decide, CRC and emit, plus the list scan and the reset reply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			out_v_q  <= 1'b0;
			scan_q   <= '0;
			rd_ok_s1 <= 1'b0;
		end else begin
			if (out_v_q && res.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						type_q    <= req.data.req_type;
						idh_q     <= req.data.id_high;
						idl_q     <= req.data.id_low;
						tok_q     <= {req.data.token_w0, req.data.token_w1,
							req.data.token_w2, req.data.token_w3};
						scan_q    <= '0;
						rd_ok_s1  <= 1'b0;
						hit_q     <= 1'b0;
						free_ok_q <= 1'b0;
						if (req.data.req_type == REQ_RESET) begin
							valid_q    <= '0;
							out_v_q    <= 1'b1;
							out_st_q   <= ST_RESET;
							out_slot_q <= '0;
							out_idh_q  <= '0;
							out_idl_q  <= '0;
							out_rel_q  <= 1'b0;
							out_last_q <= 1'b1;
						end else if (req.data.req_type == REQ_LIST) begin
							state_q <= S_LIST;
						end else if (req.data.req_type <= REQ_ERASE) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// Issue one read a cycle; check the slot read last cycle
					if (rd_ok_s1) begin
						if (valid_q[rd_idx_s1] && !hit_q && ram_rdata.id_high == idh_q
								&& ram_rdata.id_low == idl_q) begin
							hit_q     <= 1'b1;
							hit_q_idx <= rd_idx_s1;
							hit_rec_q <= ram_rdata;
						end
					end
					if (scan_q < (AW+1)'(NUM_SLOTS)) begin
						rd_ok_s1  <= 1'b1;
						rd_idx_s1 <= scan_q[AW-1:0];
						if (!valid_q[scan_q[AW-1:0]] && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q    <= scan_q[AW-1:0];
						end
						scan_q <= scan_q + 1'b1;
					end else begin
						rd_ok_s1 <= 1'b0;
						state_q  <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					out_rel_q  <= 1'b0;
					out_last_q <= 1'b1;
					out_idh_q  <= idh_q;
					out_idl_q  <= idl_q;
					out_slot_q <= 6'(hit_q_idx);
					state_q    <= S_EMIT;
					case (type_q)
						REQ_ADD: begin
							if (hit_q) begin
								valid_q[hit_q_idx] <= 1'b0;
								// freed slot may be lower than the first free one
								if (!free_ok_q || hit_q_idx < free_q) begin
									free_q <= hit_q_idx;
								end
								state_q <= S_CRC;
							end else if (free_ok_q) begin
								state_q <= S_CRC;
							end else begin
								out_st_q   <= ST_FULL;
								out_slot_q <= '0;
								out_idh_q  <= '0;
								out_idl_q  <= '0;
							end
						end
						REQ_BUY: begin
							if (hit_q) begin
								state_q <= S_CRC;
							end else begin
								out_st_q   <= ST_NOITEM;
								out_slot_q <= '0;
								out_idh_q  <= '0;
								out_idl_q  <= '0;
							end
						end
						default: begin
							if (hit_q) begin
								valid_q[hit_q_idx] <= 1'b0;
								out_st_q <= ST_ERASED;
							end else begin
								out_st_q   <= ST_NOTFOUND;
								out_slot_q <= '0;
								out_idh_q  <= '0;
								out_idl_q  <= '0;
							end
						end
					endcase
				end
				S_CRC: begin
					if (crc_done) begin
						state_q <= S_EMIT;
						if (type_q == REQ_ADD) begin
							valid_q[free_q] <= 1'b1;
							out_st_q        <= ST_ADDED;
							out_slot_q      <= 6'(free_q);
						end else if (crc_val != hit_rec_q.crc) begin
							out_st_q <= ST_CORRUPT;
						end else if (hit_rec_q.token != tok_q) begin
							out_st_q <= ST_MISMATCH;
						end else begin
							valid_q[hit_q_idx] <= 1'b0;
							out_st_q           <= ST_RELEASED;
							out_rel_q          <= 1'b1;
						end
					end
				end
				S_LIST: begin
					// One read a cycle; hold while the output register is full
					if (!(out_v_q && !res.ready)) begin
						if (rd_ok_s1 && valid_q[rd_idx_s1]) begin
							out_v_q    <= 1'b1;
							out_st_q   <= ST_LISTENT;
							out_slot_q <= 6'(rd_idx_s1);
							out_idh_q  <= ram_rdata.id_high;
							out_idl_q  <= ram_rdata.id_low;
							out_rel_q  <= 1'b0;
							out_last_q <= 1'b0;
						end
						if (scan_q < (AW+1)'(NUM_SLOTS)) begin
							rd_ok_s1  <= 1'b1;
							rd_idx_s1 <= scan_q[AW-1:0];
							scan_q    <= scan_q + 1'b1;
						end else if (rd_ok_s1) begin
							rd_ok_s1 <= 1'b0;
						end else begin
							out_v_q    <= 1'b1;
							out_st_q   <= ST_LISTEND;
							out_slot_q <= '0;
							out_idh_q  <= '0;
							out_idl_q  <= '0;
							out_rel_q  <= 1'b0;
							out_last_q <= 1'b1;
							state_q    <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (!(out_v_q && !res.ready)) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/tet_checker.sv
// Port-level checker for the token escrow table, bound to the top level.
// Depends on tet_pkg and token_escrow_table_macros.svh.
`include "token_escrow_table_macros.svh"
module tet_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [3:0]  status,
	input logic [5:0]  slot_index,
	input logic        release_res,
	input logic        last
);
	import tet_pkg::*;

	`TET_ASSERT_IMP(a_rel_only_released, clk, arst_n, res_valid && release_res, status == ST_RELEASED, "release without released status")
	`TET_ASSERT_IMP(a_last_matches, clk, arst_n, res_valid && status == ST_LISTENT, !last, "list entry marked last")
	`TET_ASSERT_IMP(a_empty_slot, clk, arst_n, res_valid && (status == ST_FULL || status == ST_LISTEND || status == ST_RESET), slot_index == 6'd0, "slot index not zero")
	`TET_ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(status), "result dropped while stalled")
endmodule

bind token_escrow_table tet_checker u_tet_checker (
	.clk(clk), .arst_n(arst_n), .res_valid(res.valid), .res_ready(res.ready),
	.status(res.data.status), .slot_index(res.data.slot_index),
	.release_res(res.data.release_res), .last(res.data.last)
);

FILE: bench/token_escrow_table_tb.sv
// Self-checking bench for the token escrow table: a queued driver, a monitor
// and a slot-table predictor. Depends on tet_pkg, tet_stream_if and the block.
`timescale 1ns / 1ps

module token_escrow_table_tb;
	import tet_pkg::*;

	localparam int SLOTS      = 8;
	localparam int WATCH_MAX  = 5000;
	localparam int HOLD_LEN   = 800;
	localparam int RAND_ITEMS = 390;
	localparam int POOL       = 12;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] id_high;
		logic [63:0] id_low;
		logic [63:0] token_w0;
		logic [63:0] token_w1;
		logic [63:0] token_w2;
		logic [63:0] token_w3;
	} escrow_req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [5:0]  slot_index;
		logic [31:0] out_id_high;
		logic [63:0] out_id_low;
		logic        release_res;
		logic        last;
	} escrow_res_t;

	logic clk;
	logic arst_n;

	tet_stream_if #(.payload_t(escrow_req_t)) req ();
	tet_stream_if #(.payload_t(escrow_res_t)) res ();

	token_escrow_table #(.NUM_SLOTS(SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.res    (res.source)
	);

	// Shadow copy of the slot table
	logic         tbl_valid [SLOTS];
	logic [31:0]  tbl_idh   [SLOTS];
	logic [63:0]  tbl_idl   [SLOTS];
	logic [255:0] tbl_tok   [SLOTS];
	logic [15:0]  tbl_crc   [SLOTS];

	escrow_req_t pending_reqs[$];
	escrow_res_t pending_replies[$];

	int  mismatches;
	int  reqs_taken;
	int  idle_cycles;
	int  send_gap;
	int  recv_wait;
	bit  req_taken;
	bit  held_off;
	bit  steady;

	// Pool of ids so that buys and erases hit stored entries
	logic [31:0]  pool_idh [POOL];
	logic [63:0]  pool_idl [POOL];
	logic [255:0] pool_tok [POOL];

	always #6 clk = ~clk;

	// CRC-16/CCITT-FALSE over valid byte, id, terminator and token
	function automatic logic [15:0] entry_crc(input logic [31:0] idh,
			input logic [63:0] idl, input logic [255:0] tok);
		logic [367:0] msg;
		logic [15:0]  c;
		msg = {8'h01, idh, idl, 8'h00, tok};
		c = 16'hFFFF;
		for (int i = 367; i >= 0; i--) begin
			c = (c[15] ^ msg[i]) ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic int find_slot(input logic [31:0] idh, input logic [63:0] idl);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && tbl_idh[i] == idh && tbl_idl[i] == idl)
				return i;
		return -1;
	endfunction

	function automatic escrow_res_t mk_res(input logic [3:0] st, input int s,
			input logic [31:0] idh, input logic [63:0] idl, input logic rel,
			input logic lst);
		escrow_res_t r;
		r.status = st;
		r.slot_index = s[5:0];
		r.out_id_high = idh;
		r.out_id_low = idl;
		r.release_res = rel;
		r.last = lst;
		return r;
	endfunction

	// Apply one request to the shadow table and queue its replies
	task automatic escrow_apply(input escrow_req_t q);
		logic [255:0] tok;
		int s;
		tok = {q.token_w0, q.token_w1, q.token_w2, q.token_w3};
		case (q.req_type)
			REQ_ADD: begin
				s = find_slot(q.id_high, q.id_low);
				if (s >= 0)
					tbl_valid[s] = 1'b0;
				s = -1;
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!tbl_valid[i])
						s = i;
				if (s < 0) begin
					pending_replies.push_back(mk_res(ST_FULL, 0, '0, '0, 1'b0, 1'b1));
				end else begin
					tbl_valid[s] = 1'b1;
					tbl_idh[s] = q.id_high;
					tbl_idl[s] = q.id_low;
					tbl_tok[s] = tok;
					tbl_crc[s] = entry_crc(q.id_high, q.id_low, tok);
					pending_replies.push_back(mk_res(ST_ADDED, s, q.id_high, q.id_low,
						1'b0, 1'b1));
				end
			end
			REQ_BUY: begin
				s = find_slot(q.id_high, q.id_low);
				if (s < 0)
					pending_replies.push_back(mk_res(ST_NOITEM, 0, '0, '0, 1'b0, 1'b1));
				else if (entry_crc(tbl_idh[s], tbl_idl[s], tbl_tok[s]) != tbl_crc[s])
					pending_replies.push_back(mk_res(ST_CORRUPT, s, q.id_high, q.id_low,
						1'b0, 1'b1));
				else if (tbl_tok[s] != tok)
					pending_replies.push_back(mk_res(ST_MISMATCH, s, q.id_high, q.id_low,
						1'b0, 1'b1));
				else begin
					tbl_valid[s] = 1'b0;
					pending_replies.push_back(mk_res(ST_RELEASED, s, q.id_high, q.id_low,
						1'b1, 1'b1));
				end
			end
			REQ_ERASE: begin
				s = find_slot(q.id_high, q.id_low);
				if (s < 0) begin
					pending_replies.push_back(mk_res(ST_NOTFOUND, 0, '0, '0, 1'b0, 1'b1));
				end else begin
					tbl_valid[s] = 1'b0;
					pending_replies.push_back(mk_res(ST_ERASED, s, q.id_high, q.id_low,
						1'b0, 1'b1));
				end
			end
			REQ_LIST: begin
				for (int i = 0; i < SLOTS; i++)
					if (tbl_valid[i])
						pending_replies.push_back(mk_res(ST_LISTENT, i, tbl_idh[i],
							tbl_idl[i], 1'b0, 1'b0));
				pending_replies.push_back(mk_res(ST_LISTEND, 0, '0, '0, 1'b0, 1'b1));
			end
			REQ_RESET: begin
				for (int i = 0; i < SLOTS; i++)
					tbl_valid[i] = 1'b0;
				pending_replies.push_back(mk_res(ST_RESET, 0, '0, '0, 1'b0, 1'b1));
			end
			default: ;
		endcase
	endtask

	task automatic report(input string what, input logic [95:0] got, input logic [95:0] want);
		mismatches++;
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	function automatic int draw_gap();
		int p;
		if (steady)
			return 0;
		p = $urandom_range(99);
		if (p < 65)
			return 0;
		if (p < 94)
			return $urandom_range(3, 1);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_req(input logic [2:0] t, input logic [31:0] idh,
			input logic [63:0] idl, input logic [255:0] tok);
		escrow_req_t q;
		q.req_type = t;
		q.id_high = idh;
		q.id_low = idl;
		{q.token_w0, q.token_w1, q.token_w2, q.token_w3} = tok;
		pending_reqs.push_back(q);
	endtask

	// Sender: offer queued transactions, hold until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (req.valid && !req_taken) begin
				req.valid <= 1'b1;
			end else if (send_gap > 0) begin
				req.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_reqs.size() > 0) begin
				req.data <= pending_reqs.pop_front();
				req.valid <= 1'b1;
				send_gap <= draw_gap();
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held_off && reqs_taken >= 150) begin
				held_off <= 1'b1;
				res.ready <= 1'b0;
				recv_wait <= HOLD_LEN;
			end else if (recv_wait > 0) begin
				res.ready <= 1'b0;
				recv_wait <= recv_wait - 1;
			end else begin
				res.ready <= 1'b1;
				if ($urandom_range(99) < 20)
					recv_wait <= draw_gap();
			end
			if ($urandom_range(199) == 0)
				steady <= ~steady;
		end
	end

	// Monitor: predict on accepted requests, check accepted replies
	always @(posedge clk) begin
		escrow_res_t want;
		req_taken <= arst_n && req.valid && req.ready;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				reqs_taken <= reqs_taken + 1;
				escrow_apply(req.data);
			end
			if (res.valid && res.ready) begin
				if (pending_replies.size() == 0) begin
					report("unexpected reply status", res.data.status, '0);
				end else begin
					want = pending_replies.pop_front();
					if (res.data.status !== want.status)
						report("status", res.data.status, want.status);
					if (res.data.slot_index !== want.slot_index)
						report("slot_index", res.data.slot_index, want.slot_index);
					if (res.data.out_id_high !== want.out_id_high)
						report("out_id_high", res.data.out_id_high, want.out_id_high);
					if (res.data.out_id_low !== want.out_id_low)
						report("out_id_low", res.data.out_id_low, want.out_id_low);
					if (res.data.release_res !== want.release_res)
						report("release_res", res.data.release_res, want.release_res);
					if (res.data.last !== want.last)
						report("last", res.data.last, want.last);
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (res.valid && res.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCH_MAX) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [255:0] tok;
		int p, k, t;
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		res.ready = 1'b0;
		mismatches = 0;
		reqs_taken = 0;
		idle_cycles = 0;
		send_gap = 0;
		recv_wait = 0;
		req_taken = 1'b0;
		held_off = 1'b0;
		steady = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			tbl_valid[i] = 1'b0;

		// Id pool: extremes plus random ids
		for (int i = 0; i < POOL; i++) begin
			pool_idh[i] = $urandom;
			pool_idl[i] = rand64();
			pool_tok[i] = {rand64(), rand64(), rand64(), rand64()};
		end
		pool_idh[0] = '0;
		pool_idl[0] = '0;
		pool_idh[1] = '1;
		pool_idl[1] = '1;

		// Directed: empty-table cases, fill to full, replace, buy, erase, list, undefined codes, reset
		queue_req(REQ_LIST, '0, '0, '0);
		queue_req(REQ_BUY, pool_idh[0], pool_idl[0], '0);
		queue_req(REQ_ERASE, pool_idh[1], pool_idl[1], '1);
		queue_req(REQ_ADD, pool_idh[0], pool_idl[0], '0);
		queue_req(REQ_ADD, pool_idh[1], pool_idl[1], '1);
		for (int i = 2; i < SLOTS; i++)
			queue_req(REQ_ADD, pool_idh[i], pool_idl[i], pool_tok[i]);
		queue_req(REQ_ADD, pool_idh[SLOTS], pool_idl[SLOTS], pool_tok[SLOTS]);
		queue_req(REQ_LIST, '0, '0, '0);
		queue_req(REQ_ERASE, pool_idh[2], pool_idl[2], '0);
		queue_req(REQ_ADD, pool_idh[5], pool_idl[5], pool_tok[5]);
		queue_req(REQ_BUY, pool_idh[1], pool_idl[1], {255'h0, 1'b1});
		queue_req(REQ_BUY, pool_idh[1], pool_idl[1], '1);
		queue_req(REQ_BUY, pool_idh[0], pool_idl[0], '0);
		queue_req(3'd5, pool_idh[3], pool_idl[3], '0);
		queue_req(3'd6, '1, '1, '1);
		queue_req(3'd7, '0, '0, '0);
		queue_req(REQ_LIST, '0, '0, '0);
		queue_req(REQ_RESET, '1, '1, '1);
		queue_req(REQ_LIST, '0, '0, '0);

		// Random: mostly pooled ids so lookups hit, buys often carry the right token
		for (int n = 0; n < RAND_ITEMS; n++) begin
			p = $urandom_range(99);
			k = $urandom_range(POOL - 1);
			tok = {rand64(), rand64(), rand64(), rand64()};
			if (p < 36) begin
				pool_tok[k] = tok;
				t = REQ_ADD;
			end else if (p < 62) begin
				t = REQ_BUY;
				if ($urandom_range(99) < 65)
					tok = pool_tok[k];
				else if ($urandom_range(1))
					tok = pool_tok[k] ^ (256'h1 << $urandom_range(255));
			end else if (p < 77) begin
				t = REQ_ERASE;
			end else if (p < 90) begin
				t = REQ_LIST;
			end else if (p < 93) begin
				t = REQ_RESET;
			end else begin
				t = $urandom_range(7, 5);
			end
			if ($urandom_range(99) < 10)
				queue_req(t[2:0], $urandom, rand64(), tok);
			else
				queue_req(t[2:0], pool_idh[k], pool_idl[k], tok);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() > 0 || req.valid)
			@(posedge clk);
		while (pending_replies.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+design
design/tet_pkg.sv
design/tet_stream_if.sv
design/tet_ram.sv
design/tet_crc.sv
design/token_escrow_table.sv
design/tet_checker.sv
bench/token_escrow_table_tb.sv
